// ===== design/tfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tfd_pkg: shared types and constants of the three-frame motion detector
// Request and result payloads, stage flags, gray weights and register codes.
// ----------------------------------------------------------------------------
package tfd_pkg;

	localparam int COUNT_WIDTH_DEF = 18;
	localparam int PIX_W           = 16;
	localparam int GRAY_W          = 6;
	localparam int SUM_W           = 16;
	localparam int OUT_COUNT_W     = 18;
	localparam int DIFF_THR_W      = 6;
	localparam int ALARM_THR_W     = 18;
	localparam int PADDR_W         = 3;

	// Gray weights on raw RGB565 field values.
	localparam logic [SUM_W-1:0] R_WEIGHT = 16'd299;
	localparam logic [SUM_W-1:0] G_WEIGHT = 16'd587;
	localparam logic [SUM_W-1:0] B_WEIGHT = 16'd114;

	// floor(s / 1000) == (s * 67109) >> 26 for every s below 65536.
	localparam logic [31:0] GRAY_RECIP = 32'd67109;
	localparam int          GRAY_SHIFT = 26;

	localparam logic [DIFF_THR_W-1:0]  DIFF_THR_RST  = 6'd3;
	localparam logic [ALARM_THR_W-1:0] ALARM_THR_RST = 18'd20;

	// Register index, taken from paddr[2].
	localparam logic REG_DIFF_THR  = 1'b0;
	localparam logic REG_ALARM_THR = 1'b1;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_first;
		logic [PIX_W-1:0] pixel_second;
		logic [PIX_W-1:0] pixel_third;
		logic             frame_end;
	} pixel_req_t;

	typedef struct packed {
		logic                   motion_pixel;
		logic [OUT_COUNT_W-1:0] motion_count;
		logic                   alarm;
		logic                   frame_done;
	} result_t;

	typedef struct packed {
		logic motion;
		logic last;
	} tfd_flag_t;

endpackage

// ===== design/tfd_gray_lane.sv =====
// ----------------------------------------------------------------------------
// tfd_gray_lane: RGB565 to gray conversion lane
// Stage 1 forms the weighted channel sum, stage 2 divides it by 1000 through
// a reciprocal multiply.
// ----------------------------------------------------------------------------
module tfd_gray_lane (
	input  logic                       clk,
	input  logic                       en_s1,
	input  logic                       en_s2,
	input  logic [tfd_pkg::PIX_W-1:0]  pixel,
	output logic [tfd_pkg::GRAY_W-1:0] gray_s2
);
	import tfd_pkg::*;

	logic [SUM_W-1:0] sum_d;
	logic [SUM_W-1:0] sum_s1;
	logic [31:0]      prod;

	// Largest sum is 49784, so 16 bits hold it without overflow.
	assign sum_d = SUM_W'(pixel[15:11]) * R_WEIGHT
	             + SUM_W'(pixel[10:5])  * G_WEIGHT
	             + SUM_W'(pixel[4:0])   * B_WEIGHT;

	assign prod = 32'(sum_s1) * GRAY_RECIP;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sum_s1 <= sum_d;
		end
		if (en_s2) begin
			gray_s2 <= prod[GRAY_SHIFT+GRAY_W-1:GRAY_SHIFT];
		end
	end

endmodule

// ===== design/tfd_merge.sv =====
// ----------------------------------------------------------------------------
// tfd_merge: combines the three gray lanes
// Forms both absolute frame differences and decides whether the position
// is moving.
// ----------------------------------------------------------------------------
module tfd_merge (
	input  logic                           clk,
	input  logic                           en_s3,
	input  logic [tfd_pkg::GRAY_W-1:0]     gray_first,
	input  logic [tfd_pkg::GRAY_W-1:0]     gray_second,
	input  logic [tfd_pkg::GRAY_W-1:0]     gray_third,
	input  logic                           last_s2,
	input  logic [tfd_pkg::DIFF_THR_W-1:0] diff_threshold,
	output tfd_pkg::tfd_flag_t             flag_s3
);
	import tfd_pkg::*;

	logic [GRAY_W-1:0] d1;
	logic [GRAY_W-1:0] d2;

	assign d1 = (gray_second > gray_first) ? gray_second - gray_first
	                                       : gray_first - gray_second;
	assign d2 = (gray_third > gray_second) ? gray_third - gray_second
	                                       : gray_second - gray_third;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			flag_s3.motion <= (d1 == d2) && (d1 > diff_threshold);
			flag_s3.last   <= last_s2;
		end
	end

endmodule

// ===== design/tfd_tally.sv =====
// ----------------------------------------------------------------------------
// tfd_tally: saturating motion counter and result register
// Counts motion positions per frame, raises the alarm at frame end and
// clears for the next frame.
// ----------------------------------------------------------------------------
module tfd_tally #(
	parameter int COUNT_WIDTH = tfd_pkg::COUNT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en_s4,
	input  logic                            valid_s3,
	input  tfd_pkg::tfd_flag_t              flag_s3,
	input  logic [tfd_pkg::ALARM_THR_W-1:0] alarm_threshold,
	output tfd_pkg::result_t                result_s4
);
	import tfd_pkg::*;

	localparam int EXT_W = COUNT_WIDTH + OUT_COUNT_W;

	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] count_next;
	logic [EXT_W-1:0]       count_ext;
	logic [EXT_W-1:0]       thr_ext;

	assign count_next = (flag_s3.motion && (count_q != {COUNT_WIDTH{1'b1}}))
	                  ? count_q + COUNT_WIDTH'(1) : count_q;
	assign count_ext  = EXT_W'(count_next);
	assign thr_ext    = EXT_W'(alarm_threshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en_s4 && valid_s3) begin
			count_q <= flag_s3.last ? '0 : count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			result_s4.motion_pixel <= flag_s3.motion;
			result_s4.motion_count <= count_ext[OUT_COUNT_W-1:0];
			result_s4.alarm        <= flag_s3.last && (count_ext > thr_ext);
			result_s4.frame_done   <= flag_s3.last;
		end
	end

endmodule

// ===== design/three_frame_difference_motion_detect_unit.sv =====
// ----------------------------------------------------------------------------
// three_frame_difference_motion_detect_unit: three-frame motion detector
// Marks moving pixel positions and counts them per frame with an alarm.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the pixel channel carries the RGB565 pixel at one position
// from three successive frames plus a frame-end mark. Three gray lanes
// convert the pixels side by side, a merge stage compares the two frame
// differences and a tally stage keeps the per-frame motion count.
// Every request yields exactly one result on the result channel, through the
// stages s1 to s4 in order. One request is taken per clock in steady state
// while the receiver takes results; the four-stage pipeline sets the latency.
// The frame-end result carries the final count and the alarm flag; the
// counter then starts the next frame from zero.
// Reset clears the pipeline and the counter and sets the two thresholds to 3 and 20.
// When the receiver stalls, the stages fill up and pixel_ready drops once
// all four hold a request; empty stages keep accepting meanwhile.
// Thresholds are written over the APB port at 0x0 and 0x4, by the user only while idle; the block does not check.
// ----------------------------------------------------------------------------
module three_frame_difference_motion_detect_unit #(
	parameter int COUNT_WIDTH = tfd_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pixel_valid,
	output logic                        pixel_ready,
	input  tfd_pkg::pixel_req_t         pixel,
	output logic                        result_valid,
	input  logic                        result_ready,
	output tfd_pkg::result_t            result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tfd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import tfd_pkg::*;

	logic [DIFF_THR_W-1:0]  diff_thr_q;
	logic [ALARM_THR_W-1:0] alarm_thr_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv1, adv2, adv3, adv4;
	logic last_s1, last_s2;

	logic [GRAY_W-1:0] gray1_s2, gray2_s2, gray3_s2;
	tfd_flag_t         flag_s3;

	// A stage loads when it is empty or its contents move on.
	assign adv4 = !valid_s4 || result_ready;
	assign adv3 = !valid_s3 || adv4;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign pixel_ready  = adv1;
	assign result_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= pixel_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
			if (adv4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			last_s1 <= pixel.frame_end;
		end
		if (adv2) begin
			last_s2 <= last_s1;
		end
	end

	tfd_gray_lane u_lane_first (
		.clk     (clk),
		.en_s1   (adv1),
		.en_s2   (adv2),
		.pixel   (pixel.pixel_first),
		.gray_s2 (gray1_s2)
	);

	tfd_gray_lane u_lane_second (
		.clk     (clk),
		.en_s1   (adv1),
		.en_s2   (adv2),
		.pixel   (pixel.pixel_second),
		.gray_s2 (gray2_s2)
	);

	tfd_gray_lane u_lane_third (
		.clk     (clk),
		.en_s1   (adv1),
		.en_s2   (adv2),
		.pixel   (pixel.pixel_third),
		.gray_s2 (gray3_s2)
	);

	tfd_merge u_merge (
		.clk            (clk),
		.en_s3          (adv3),
		.gray_first     (gray1_s2),
		.gray_second    (gray2_s2),
		.gray_third     (gray3_s2),
		.last_s2        (last_s2),
		.diff_threshold (diff_thr_q),
		.flag_s3        (flag_s3)
	);

	tfd_tally #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_tally (
		.clk             (clk),
		.arst_n          (arst_n),
		.en_s4           (adv4),
		.valid_s3        (valid_s3),
		.flag_s3         (flag_s3),
		.alarm_threshold (alarm_thr_q),
		.result_s4       (result)
	);

	// Configuration registers.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_thr_q  <= DIFF_THR_RST;
			alarm_thr_q <= ALARM_THR_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_DIFF_THR:  diff_thr_q  <= pwdata[DIFF_THR_W-1:0];
				REG_ALARM_THR: alarm_thr_q <= pwdata[ALARM_THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_DIFF_THR:  prdata = 32'(diff_thr_q);
			REG_ALARM_THR: prdata = 32'(alarm_thr_q);
			default:       prdata = '0;
		endcase
	end

endmodule

// ===== bench/motion_tally_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motion_tally_checker: result checker for the three-frame motion detector
// Watches the pixel, result and APB channels. It predicts each result from
// its own copy of the thresholds and the per-frame motion tally, and
// compares every accepted result, field by field, with the oldest
// prediction.
// ----------------------------------------------------------------------------
module motion_tally_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pixel_valid,
	input  logic                        pixel_ready,
	input  tfd_pkg::pixel_req_t         pixel,
	input  logic                        result_valid,
	input  logic                        result_ready,
	input  tfd_pkg::result_t            result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tfd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	input  logic [31:0]                 prdata,
	input  logic                        pready,
	output int                          mismatches,
	output int                          outstanding
);
	import tfd_pkg::*;

	localparam int PRINT_CAP = 40;

	logic [DIFF_THR_W-1:0]      diff_thr;
	logic [ALARM_THR_W-1:0]     alarm_thr;
	logic [COUNT_WIDTH_DEF-1:0] frame_tally;
	result_t                    due_results[$];

	initial mismatches = 0;

	function automatic int unsigned gray_level(input logic [PIX_W-1:0] p);
		int unsigned r, g, b;
		r = p[15:11];
		g = p[10:5];
		b = p[4:0];
		return (299 * r + 587 * g + 114 * b) / 1000;
	endfunction

	// Updates the frame tally as a side effect, in request order.
	function automatic result_t predict_motion(input pixel_req_t req);
		int unsigned g1, g2, g3, d1, d2;
		result_t res;
		g1 = gray_level(req.pixel_first);
		g2 = gray_level(req.pixel_second);
		g3 = gray_level(req.pixel_third);
		d1 = (g2 > g1) ? g2 - g1 : g1 - g2;
		d2 = (g3 > g2) ? g3 - g2 : g2 - g3;
		res.motion_pixel = (d1 == d2) && (d1 > diff_thr);
		if (res.motion_pixel && frame_tally != '1)
			frame_tally = frame_tally + 1'b1;
		res.motion_count = frame_tally;
		res.alarm        = req.frame_end && (frame_tally > alarm_thr);
		res.frame_done   = req.frame_end;
		if (req.frame_end)
			frame_tally = '0;
		return res;
	endfunction

	// Every mismatch is counted; only the first few are printed.
	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch @%0t: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			diff_thr    = DIFF_THR_RST;
			alarm_thr   = ALARM_THR_RST;
			frame_tally = '0;
			due_results.delete();
			outstanding <= 0;
		end else begin
			if (pixel_valid && pixel_ready)
				due_results.push_back(predict_motion(pixel));
			if (result_valid && result_ready) begin
				if (due_results.size() == 0) begin
					report("result arrived with no request outstanding");
				end else begin
					want = due_results.pop_front();
					if (result.motion_pixel !== want.motion_pixel)
						report($sformatf("motion_pixel got %0d, expected %0d",
							result.motion_pixel, want.motion_pixel));
					if (result.motion_count !== want.motion_count)
						report($sformatf("motion_count got %0d, expected %0d",
							result.motion_count, want.motion_count));
					if (result.alarm !== want.alarm)
						report($sformatf("alarm got %0d, expected %0d",
							result.alarm, want.alarm));
					if (result.frame_done !== want.frame_done)
						report($sformatf("frame_done got %0d, expected %0d",
							result.frame_done, want.frame_done));
				end
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_DIFF_THR)
						diff_thr = pwdata[DIFF_THR_W-1:0];
					else
						alarm_thr = pwdata[ALARM_THR_W-1:0];
				end else if (paddr[2] == REG_DIFF_THR) begin
					if (prdata !== 32'(diff_thr))
						report($sformatf("diff_threshold read %0d, expected %0d",
							prdata, diff_thr));
				end else begin
					if (prdata !== 32'(alarm_thr))
						report($sformatf("alarm_threshold read %0d, expected %0d",
							prdata, alarm_thr));
				end
			end
			outstanding <= due_results.size();
		end
	end

endmodule

// ===== bench/three_frame_difference_motion_detect_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_frame_difference_motion_detect_unit_tb: motion detector testbench
// Drives pixel requests and threshold writes through several threshold
// settings, with random idling on both channels and a long result stall.
// The checker beside the block predicts and compares every result; this
// module gives the verdict.
// ----------------------------------------------------------------------------
module three_frame_difference_motion_detect_unit_tb;
	import tfd_pkg::*;

	localparam logic [PADDR_W-1:0] DIFF_THR_ADDR  = {REG_DIFF_THR, 2'b00};
	localparam logic [PADDR_W-1:0] ALARM_THR_ADDR = {REG_ALARM_THR, 2'b00};
	localparam int GRAY_TOP     = 49;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_CYCLES = 40;

	logic                clk;
	logic                arst_n;
	logic                pixel_valid;
	logic                pixel_ready;
	pixel_req_t          pixel;
	logic                result_valid;
	logic                result_ready;
	result_t             result;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	int                  mismatches;
	int                  outstanding;

	logic                hold_results = 1'b0;
	logic                calm = 1'b0;
	int                  diff_set;

	// All pixel codes sorted by gray level, with the first index of each level.
	logic [PIX_W-1:0]    shade_pix [0:65535];
	int                  shade_base [0:GRAY_TOP+1];

	three_frame_difference_motion_detect_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	motion_tally_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("** three_frame_difference_motion_detect_unit: FAILED **");
		$finish;
	end

	function automatic int shade_of(input logic [PIX_W-1:0] p);
		int r, g, b;
		r = p[15:11];
		g = p[10:5];
		b = p[4:0];
		return (299 * r + 587 * g + 114 * b) / 1000;
	endfunction

	function automatic logic [PIX_W-1:0] pixel_for_gray(input int g);
		return shade_pix[$urandom_range(shade_base[g+1] - 1, shade_base[g])];
	endfunction

	function automatic pixel_req_t pack_px(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c, input logic fe);
		pixel_req_t req;
		req.pixel_first  = a;
		req.pixel_second = b;
		req.pixel_third  = c;
		req.frame_end    = fe;
		return req;
	endfunction

	// Three pixels whose gray levels step by d1 and then by d2, each step up
	// or down at random, with the middle level placed so that all fit.
	function automatic pixel_req_t shaped_req(input int d1, input int d2, input logic fe);
		bit up1, up2;
		int lo, hi, g2;
		up1 = 1'($urandom_range(0, 1));
		up2 = 1'($urandom_range(0, 1));
		lo = 0;
		hi = GRAY_TOP;
		if (up1)
			hi = GRAY_TOP - d1;
		else
			lo = d1;
		if (up2) begin
			if (GRAY_TOP - d2 < hi)
				hi = GRAY_TOP - d2;
		end else if (d2 > lo) begin
			lo = d2;
		end
		if (lo > hi) begin
			up1 = 1'b0;
			up2 = 1'b0;
			lo = (d1 > d2) ? d1 : d2;
			hi = GRAY_TOP;
		end
		g2 = $urandom_range(hi, lo);
		return pack_px(pixel_for_gray(up1 ? g2 + d1 : g2 - d1), pixel_for_gray(g2),
			pixel_for_gray(up2 ? g2 + d2 : g2 - d2), fe);
	endfunction

	// Mostly equal differences, half of them near the threshold, some that miss by one,
	// and the rest fully random pixels.
	function automatic pixel_req_t random_req();
		int kind, d;
		logic fe;
		kind = $urandom_range(0, 99);
		fe = ($urandom_range(0, 11) == 0);
		if ($urandom_range(0, 1))
			d = diff_set + $urandom_range(0, 3);
		else
			d = $urandom_range(0, GRAY_TOP);
		if (d > GRAY_TOP)
			d = GRAY_TOP;
		if (kind < 55)
			return shaped_req(d, d, fe);
		if (kind < 75) begin
			if (d == GRAY_TOP)
				return shaped_req(d, d - 1, fe);
			if ($urandom_range(0, 1))
				return shaped_req(d, d + 1, fe);
			return shaped_req(d + 1, d, fe);
		end
		return pack_px(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), fe);
	endfunction

	task automatic send_pixel(input pixel_req_t req);
		if (!calm && $urandom_range(0, 4) == 0) begin
			pixel_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel       <= req;
		do @(posedge clk); while (!pixel_ready);
	endtask

	task automatic run_random(input int n);
		repeat (n) send_pixel(random_req());
	endtask

	task automatic wait_drained();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Leaves the bus idle until the next edge after the access so that
	// back-to-back calls never assign psel twice in the same step.
	task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
			input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_thresholds(input logic [31:0] diff_raw, input logic [31:0] alarm_raw);
		wait_drained();
		apb_access(1'b1, DIFF_THR_ADDR, diff_raw);
		apb_access(1'b1, ALARM_THR_ADDR, alarm_raw);
		apb_access(1'b0, DIFF_THR_ADDR, 32'd0);
		apb_access(1'b0, ALARM_THR_ADDR, 32'd0);
		diff_set = int'(diff_raw[DIFF_THR_W-1:0]);
	endtask

	// Result side: short random stalls, and one long stall on request.
	initial begin : drain_side
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_results) begin
				result_ready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
				hold_results <= 1'b0;
				result_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int fill [0:GRAY_TOP];
		int gl;
		arst_n      = 1'b0;
		pixel_valid = 1'b0;
		pixel       = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		diff_set    = int'(DIFF_THR_RST);

		for (int g = 0; g <= GRAY_TOP + 1; g++)
			shade_base[g] = 0;
		for (int p = 0; p < 65536; p++)
			shade_base[shade_of(p[15:0]) + 1]++;
		for (int g = 1; g <= GRAY_TOP + 1; g++)
			shade_base[g] += shade_base[g-1];
		for (int g = 0; g <= GRAY_TOP; g++)
			fill[g] = shade_base[g];
		for (int p = 0; p < 65536; p++) begin
			gl = shade_of(p[15:0]);
			shade_pix[fill[gl]] = p[15:0];
			fill[gl]++;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests under the reset thresholds.
		send_pixel(pack_px(16'h0000, 16'h0000, 16'h0000, 1'b0));
		send_pixel(pack_px(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
		send_pixel(pack_px(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0));
		send_pixel(pack_px(16'h0000, 16'hFFFF, 16'h0000, 1'b0));
		send_pixel(pack_px(16'h0000, 16'h0000, 16'hFFFF, 1'b0));
		send_pixel(pack_px(16'hFFFF, 16'h0000, 16'h0000, 1'b0));
		send_pixel(pack_px(16'hF800, 16'h0000, 16'hF800, 1'b0));
		send_pixel(pack_px(16'h07E0, 16'h0000, 16'h07E0, 1'b0));
		send_pixel(pack_px(16'h001F, 16'h0000, 16'h001F, 1'b0));
		send_pixel(pack_px(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0));
		send_pixel(shaped_req(3, 3, 1'b0));
		send_pixel(shaped_req(4, 4, 1'b0));
		send_pixel(shaped_req(4, 5, 1'b0));
		send_pixel(shaped_req(GRAY_TOP, GRAY_TOP, 1'b1));
		send_pixel(pack_px(16'h0000, 16'h0000, 16'h0000, 1'b1));
		send_pixel(shaped_req(10, 10, 1'b1));
		send_pixel(pack_px(16'h5555, 16'hAAAA, 16'h5555, 1'b1));
		run_random(130);

		set_thresholds(32'd0, 32'd0);
		run_random(60);
		hold_results <= 1'b1;
		run_random(70);

		set_thresholds(32'd63, 32'd262143);
		run_random(130);

		set_thresholds(32'd5, 32'd7);
		run_random(60);
		wait_drained();
		run_random(70);

		// High bits beyond each register's width must be dropped.
		set_thresholds(32'hFFFF_FFC2, 32'hFFFC_000A);
		run_random(130);

		set_thresholds($urandom_range(12, 1), $urandom_range(30, 0));
		run_random(130);

		// Final stretch runs without idling on either side.
		calm <= 1'b1;
		set_thresholds(32'(DIFF_THR_RST), 32'(ALARM_THR_RST));
		run_random(150);

		wait_drained();
		if (mismatches == 0 && outstanding == 0)
			$display("** three_frame_difference_motion_detect_unit: PASSED **");
		else
			$display("** three_frame_difference_motion_detect_unit: FAILED **");
		$finish;
	end

endmodule
